[hw/rtl/ctk_pkg.sv]
package ctk_pkg;

   localparam int TOP_COUNT_DEF    = 25;
   localparam int SAMPLE_WIDTH_DEF = 16;

   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_SAMPLE      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CONSOLIDATE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR       = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_READING = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_READING = 2'd1;

   // controller -> datapath
   typedef struct packed {
      logic load;       // latch the request word
      logic exec;       // apply the latched item to the window state
      logic div_start;  // set up the mean divider
      logic div_step;   // one quotient bit
      logic out_load;   // move the result into the response register
   } ctk_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_needed;
      logic div_last;
      logic out_free;
   } ctk_status_type;

endpackage

[hw/rtl/ctk_req_if.sv]
interface ctk_req_if #(
   parameter int SAMPLE_WIDTH = ctk_pkg::SAMPLE_WIDTH_DEF
) ();
   import ctk_pkg::*;

   logic                           valid;
   logic                           ready;
   logic        [KIND_W-1:0]       kind;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, kind, sample, input ready);
   modport sink   (input valid, kind, sample, output ready);
endinterface

[hw/rtl/ctk_rsp_if.sv]
interface ctk_rsp_if #(
   parameter int SAMPLE_WIDTH = ctk_pkg::SAMPLE_WIDTH_DEF
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-5:0] latest_integer;
   logic signed [SAMPLE_WIDTH-1:0] consolidated_value;

   modport source (output valid, latest_integer, consolidated_value, input ready);
   modport sink   (input valid, latest_integer, consolidated_value, output ready);
endinterface

[hw/rtl/ctk_ctrl.sv]
module ctk_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ctk_pkg::ctk_status_type status,
   output ctk_pkg::ctk_cmd_type    cmd
);
   import ctk_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.div_needed) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            // wait here while the previous word still sits in the response register
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> state_ff == ST_DIV || state_ff == ST_FIN)
      else $error("exec state held longer than one cycle");
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("response overwritten before it was taken");
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && status.div_last |=> state_ff == ST_FIN)
      else $error("divider did not hand over to finish");
`endif
endmodule

[hw/rtl/ctk_dp.sv]
module ctk_dp #(
   parameter int TOP_COUNT    = ctk_pkg::TOP_COUNT_DEF,
   parameter int SAMPLE_WIDTH = ctk_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ctk_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [SAMPLE_WIDTH-1:0]            csr_wdata,
   input  logic [ctk_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [SAMPLE_WIDTH-1:0]     req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_WIDTH-5:0]     rsp_latest_integer,
   output logic signed [SAMPLE_WIDTH-1:0]     rsp_consolidated_value,
   input  ctk_pkg::ctk_cmd_type               cmd,
   output ctk_pkg::ctk_status_type            status
);
   import ctk_pkg::*;

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CNT_W = $clog2(TOP_COUNT + 1);
   localparam int SUM_W = SW + $clog2(TOP_COUNT);
   localparam int DIV_W = SUM_W + 1;
   localparam int BIT_W = $clog2(DIV_W);

   // latched request
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic signed [SW-1:0] sample_ff, sample_in;
   // bounds
   logic signed [SW-1:0] min_ff, min_in, max_ff, max_in;
   // window state, top_ff sorted descending
   logic signed [SW-1:0]    top_ff [TOP_COUNT];
   logic signed [SW-1:0]    top_in [TOP_COUNT];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SW-1:0]    latest_ff, latest_in;
   logic signed [SW-1:0]    cons_ff, cons_in;
   // bit-serial divider
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             neg_ff, neg_in;
   // response register
   logic                 out_valid_ff, out_valid_in;
   logic signed [SW-5:0] out_lat_ff, out_lat_in;
   logic signed [SW-1:0] out_cons_ff, out_cons_in;

   // insertion datapath
   logic signed [SW-1:0]    v_lo, v_cl;
   logic                    full, take;
   logic [CNT_W-1:0]        last;
   logic [TOP_COUNT-1:0]    below;
   logic signed [SW-1:0]    ins [TOP_COUNT];
   logic signed [SUM_W-1:0] sum_delta;
   // divider
   logic [SUM_W-1:0]  mag;
   logic [CNT_W:0]    trial;
   logic              ge;
   logic [DIV_W-1:0]  quo_step, quo_signed;
   logic signed [SW-1:0] lat_adj;

   always_comb begin
      v_lo = (sample_ff < min_ff) ? min_ff : sample_ff;
      v_cl = (v_lo > max_ff) ? max_ff : v_lo;
      full = (count_ff == CNT_W'(TOP_COUNT));
      last = full ? CNT_W'(TOP_COUNT - 1) : count_ff;
      take = !full || (v_cl > top_ff[TOP_COUNT-1]);
      for (int i = 0; i < TOP_COUNT; i++) begin
         below[i] = (CNT_W'(i) < last) && (top_ff[i] < v_cl);
      end
      // entries at and after the slot shift down by one, the new word drops in
      ins[0] = (below[0] || last == '0) ? v_cl : top_ff[0];
      for (int i = 1; i < TOP_COUNT; i++) begin
         if (below[i-1])                           ins[i] = top_ff[i-1];
         else if (below[i] || CNT_W'(i) == last)   ins[i] = v_cl;
         else                                      ins[i] = top_ff[i];
      end
      sum_delta = full ? (SUM_W'(v_cl) - SUM_W'(top_ff[TOP_COUNT-1])) : SUM_W'(v_cl);
   end

   always_comb begin
      mag        = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      trial      = {rem_ff, quo_ff[DIV_W-1]};
      ge         = trial >= {1'b0, count_ff};
      quo_step   = {quo_ff[DIV_W-2:0], ge};
      quo_signed = neg_ff ? (~quo_step + DIV_W'(1)) : quo_step;
      // truncate toward zero
      lat_adj    = latest_ff[SW-1] ? (latest_ff + SW'(15)) : latest_ff;
   end

   always_comb begin
      kind_in      = kind_ff;
      sample_in    = sample_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      top_in       = top_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      latest_in    = latest_ff;
      cons_in      = cons_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_lat_in   = out_lat_ff;
      out_cons_in  = out_cons_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_MIN_READING: min_in = csr_wdata;
            CSR_MAX_READING: max_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         kind_in   = req_kind;
         sample_in = req_sample;
      end

      if (cmd.exec) begin
         case (kind_ff)
            KIND_SAMPLE: begin
               latest_in = sample_ff;
               if (take) begin
                  top_in = ins;
                  sum_in = sum_ff + sum_delta;
                  if (!full) count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_CONSOLIDATE: begin
               if (count_ff == '0) cons_in = '0;
            end
            KIND_CLEAR: begin
               count_in = '0;
               sum_in   = '0;
            end
            default: ;
         endcase
      end

      if (cmd.div_start) begin
         // rounded mean: (|sum| + n/2) / n
         quo_in = DIV_W'(mag) + DIV_W'(count_ff >> 1);
         rem_in = '0;
         bit_in = BIT_W'(DIV_W - 1);
         neg_in = sum_ff[SUM_W-1];
      end

      if (cmd.div_step) begin
         rem_in = ge ? CNT_W'(trial - {1'b0, count_ff}) : CNT_W'(trial);
         quo_in = quo_step;
         bit_in = bit_ff - BIT_W'(1);
         if (bit_ff == '0) cons_in = quo_signed[SW-1:0];
      end

      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_lat_in   = lat_adj[SW-1:4];
         out_cons_in  = cons_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff       <= {1'b1, {(SW-1){1'b0}}};
         max_ff       <= {1'b0, {(SW-1){1'b1}}};
         count_ff     <= '0;
         sum_ff       <= '0;
         latest_ff    <= '0;
         cons_ff      <= '0;
         bit_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         min_ff       <= min_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         latest_ff    <= latest_in;
         cons_ff      <= cons_in;
         bit_ff       <= bit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      sample_ff   <= sample_in;
      top_ff      <= top_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      out_lat_ff  <= out_lat_in;
      out_cons_ff <= out_cons_in;
   end

   assign status.div_needed    = (kind_ff == KIND_CONSOLIDATE) && (count_ff != '0);
   assign status.div_last      = (bit_ff == '0);
   assign status.out_free      = !out_valid_ff || rsp_ready;
   assign rsp_valid            = out_valid_ff;
   assign rsp_latest_integer   = out_lat_ff;
   assign rsp_consolidated_value = out_cons_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TOP_COUNT))
      else $error("kept count above store depth");
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> sum_ff == '0)
      else $error("empty window with nonzero sum");
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_latest_integer)
         && $stable(rsp_consolidated_value))
      else $error("response word changed while stalled");
`endif
endmodule

[hw/rtl/clamped_top_k_mean.sv]
// Clamped top-K mean over a window of Q12.4 sensor samples.
// Request channel (req_if) carries kind and sample: kind 0 clamps the sample
// to [min_reading, max_reading] (max wins if the bounds cross) and inserts it
// into a sorted store of the TOP_COUNT largest; kind 1 stores the rounded
// mean of the kept samples; kind 2 empties the window. Every request gives
// one response word (rsp_if): the latest raw sample truncated to an integer
// and the last consolidated mean.
// Flow: a request is taken only while the block is idle. The word is latched,
// applied to the window in the exec state and, for a consolidate of a
// non-empty window, run through the bit-serial divider, then moved into the
// response register in the finish state; only then is a new request taken.
// The response sits in an output register, so the next request is taken while
// it waits; if the receiver stalls, the following result holds in the block
// until the register frees, and no further request is taken meanwhile.
// Reset (synchronous) empties the window, zeroes latest sample and mean, and
// opens the bounds to the full range. The sorted store needs no clearing.
// Bounds are written through csr_we/csr_index/csr_wdata; the user must write
// them only while idle, a rule the block itself does not enforce.
module clamped_top_k_mean #(
   parameter int TOP_COUNT    = ctk_pkg::TOP_COUNT_DEF,
   parameter int SAMPLE_WIDTH = ctk_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ctk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [SAMPLE_WIDTH-1:0]         csr_wdata,
   ctk_req_if.sink                         req_if,
   ctk_rsp_if.source                       rsp_if
);
   import ctk_pkg::*;

   ctk_cmd_type    cmd;
   ctk_status_type status;

   ctk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ctk_dp #(
      .TOP_COUNT    (TOP_COUNT),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_kind               (req_if.kind),
      .req_sample             (req_if.sample),
      .rsp_valid              (rsp_if.valid),
      .rsp_ready              (rsp_if.ready),
      .rsp_latest_integer     (rsp_if.latest_integer),
      .rsp_consolidated_value (rsp_if.consolidated_value),
      .cmd                    (cmd),
      .status                 (status)
   );
endmodule
